>>> design/utf8_stream_decoder_top_assert.svh
// assertion macros for the utf8 stream decoder
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define U8D_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define U8D_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

>>> design/u8d_pkg.sv
// shared types and constants of the utf8 stream decoder
`default_nettype none

package u8d_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned LEN_W   = 3;
   localparam int unsigned HELD_W  = 2;
   localparam int unsigned COUNT_W = 3;

   // sequence lengths; none means no sequence is open
   localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
   localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

   // lead and continuation byte tags
   localparam logic [1:0] TAG_CONT  = 2'b10;
   localparam logic [2:0] TAG_LEAD2 = 3'b110;
   localparam logic [3:0] TAG_LEAD3 = 4'b1110;
   localparam logic [4:0] TAG_LEAD4 = 5'b11110;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              end_of_text;
   } req_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            is_invalid;
      logic            last_of_run;
      logic            text_done;
   } rsp_type;

   // results caused by one byte: bad_count invalids, then an optional code point
   typedef struct packed {
      logic [COUNT_W-1:0] bad_count;
      logic               has_cp;
      logic [CP_W-1:0]    cp;
      logic               done;
   } run_type;

endpackage

`default_nettype wire

>>> design/u8d_decode.sv
// sequence state and per-byte decode of the utf8 stream decoder
`default_nettype none

module u8d_decode (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_fire,
   input  wire u8d_pkg::req_type req_data,
   output u8d_pkg::run_type      run
);

   logic [u8d_pkg::LEN_W-1:0]  exp_ff, exp_in;
   logic [u8d_pkg::HELD_W-1:0] held_ff, held_in;
   logic [u8d_pkg::CP_W-1:0]   partial_ff, partial_in;

   logic [u8d_pkg::BYTE_W-1:0] b;
   logic                       last;
   logic                       seq_open;
   logic                       is_cont;
   logic [u8d_pkg::HELD_W-1:0] held_inc;
   logic [u8d_pkg::CP_W-1:0]   partial_ext;
   logic                       complete;
   logic                       lead_ascii;
   logic                       lead_bad;
   logic                       lead_open;
   logic [u8d_pkg::LEN_W-1:0]  lead_len;
   logic [u8d_pkg::CP_W-1:0]   lead_payload;
   logic [u8d_pkg::COUNT_W-1:0] base_bad;

   assign b           = req_data.byte_value;
   assign last        = req_data.end_of_text;
   assign seq_open    = (exp_ff != u8d_pkg::LEN_NONE);
   assign is_cont     = (b[7:6] == u8d_pkg::TAG_CONT);
   assign held_inc    = held_ff + 2'd1;
   assign partial_ext = {partial_ff[u8d_pkg::CP_W-7:0], b[5:0]};
   // a four byte sequence completes when the held count wraps
   assign complete    = ({1'b0, held_inc} == exp_ff) || (held_inc == 2'd0);

   // lead byte classification
   always_comb begin
      lead_ascii = ~b[7];
      if (b[7:5] == u8d_pkg::TAG_LEAD2) begin
         lead_len     = u8d_pkg::LEN_TWO;
         lead_payload = {16'd0, b[4:0]};
      end else if (b[7:4] == u8d_pkg::TAG_LEAD3) begin
         lead_len     = u8d_pkg::LEN_THREE;
         lead_payload = {17'd0, b[3:0]};
      end else if (b[7:3] == u8d_pkg::TAG_LEAD4) begin
         lead_len     = u8d_pkg::LEN_FOUR;
         lead_payload = {18'd0, b[2:0]};
      end else begin
         lead_len     = u8d_pkg::LEN_NONE;
         lead_payload = '0;
      end
      lead_bad  = ~lead_ascii && ((lead_len == u8d_pkg::LEN_NONE) || last);
      lead_open = ~lead_ascii && ~lead_bad;
   end

   // result run and next sequence state
   always_comb begin
      run      = '0;
      run.done = last;
      exp_in     = exp_ff;
      held_in    = held_ff;
      partial_in = partial_ff;
      base_bad   = '0;
      if (seq_open && is_cont) begin
         if (complete) begin
            run.has_cp = 1'b1;
            run.cp     = partial_ext;
            exp_in     = u8d_pkg::LEN_NONE;
            held_in    = '0;
            partial_in = '0;
         end else if (last) begin
            // cut off by end of text: every held byte and the cut-off byte are rejected
            run.bad_count = {1'b0, held_inc};
            exp_in        = u8d_pkg::LEN_NONE;
            held_in       = '0;
            partial_in    = '0;
         end else begin
            held_in    = held_inc;
            partial_in = partial_ext;
         end
      end else begin
         // broken sequence flushes held bytes, then the byte is a new lead
         if (seq_open) begin
            base_bad = {1'b0, held_ff};
         end
         run.bad_count = base_bad + {2'b00, lead_bad};
         run.has_cp    = lead_ascii;
         run.cp        = {13'd0, b};
         if (lead_open) begin
            exp_in     = lead_len;
            held_in    = 2'd1;
            partial_in = lead_payload;
         end else begin
            exp_in     = u8d_pkg::LEN_NONE;
            held_in    = '0;
            partial_in = '0;
         end
      end
      if (last) begin
         exp_in     = u8d_pkg::LEN_NONE;
         held_in    = '0;
         partial_in = '0;
      end
   end

   // sequence state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff     <= u8d_pkg::LEN_NONE;
         held_ff    <= '0;
         partial_ff <= '0;
      end else if (in_fire) begin
         exp_ff     <= exp_in;
         held_ff    <= held_in;
         partial_ff <= partial_in;
      end
   end

endmodule

`default_nettype wire

>>> design/utf8_stream_decoder_top.sv
// UTF-8 stream decoder: takes one byte per request and returns code points or
// invalid markers. A byte is decoded in the cycle it is accepted and its
// results are held in a pending register that drives the result port; the
// first result is offered the cycle after acceptance. A byte that causes no
// result or one result does not hold up the next byte, so one byte per cycle
// is sustained while the consumer keeps rsp_ready high. A byte that causes
// n results (up to four, after a broken or cut-off sequence) occupies the
// single result port until its last result leaves, and the next byte is taken
// in the cycle that result leaves. Reset leaves no sequence open.
`default_nettype none

module utf8_stream_decoder_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire u8d_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output u8d_pkg::rsp_type      rsp_data
);

   `include "utf8_stream_decoder_top_assert.svh"

   logic [u8d_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic                        has_cp_ff;
   logic [u8d_pkg::CP_W-1:0]    cp_ff;
   logic                        done_ff;

   u8d_pkg::run_type run;
   logic req_fire;
   logic rsp_fire;
   logic final_one;

   // per-byte decode and sequence state
   u8d_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (req_fire),
      .req_data (req_data),
      .run      (run)
   );

   // handshakes; a new byte enters as the last pending result leaves
   assign final_one = (rem_ff == 3'd1);
   assign rsp_valid = (rem_ff != '0);
   assign req_ready = (rem_ff == '0) || (rsp_ready && final_one);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // current result from the pending run: invalids first, code point last
   always_comb begin
      rsp_data.is_invalid  = ~(final_one && has_cp_ff);
      rsp_data.code_point  = (final_one && has_cp_ff) ? cp_ff : '0;
      rsp_data.last_of_run = final_one;
      rsp_data.text_done   = final_one && done_ff;
   end

   // pending result count
   always_comb begin
      rem_in = rem_ff;
      if (req_fire) begin
         rem_in = run.bad_count + {2'b00, run.has_cp};
      end else if (rsp_fire) begin
         rem_in = rem_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   // pending run payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         has_cp_ff <= run.has_cp;
         cp_ff     <= run.cp;
         done_ff   <= run.done;
      end
   end

   // checks
   `U8D_ASSERT_SAME(a_accept_only_on_drain, clock, reset,
      req_fire && (rem_ff != '0), rsp_ready && final_one,
      "byte accepted while results still pending")
   `U8D_ASSERT_SAME(a_done_on_last, clock, reset,
      rsp_valid && rsp_data.text_done, rsp_data.last_of_run,
      "text done flagged on a result that is not last of its run")
   `U8D_ASSERT_SAME(a_invalid_zero_cp, clock, reset,
      rsp_valid && rsp_data.is_invalid, rsp_data.code_point == '0,
      "invalid result carries a code point")
   `U8D_ASSERT_NEXT(a_end_gives_result, clock, reset,
      req_fire && req_data.end_of_text, rsp_valid,
      "end of text byte produced no result")

endmodule

`default_nettype wire

>>> test/u8d_code_point_checker.sv
// checker: predicts the decoded code points and compares them with the result port
module u8d_code_point_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_ready,
   input  wire u8d_pkg::req_type req_data,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire u8d_pkg::rsp_type rsp_data,
   output int                    mismatch_count,
   output int                    points_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // open multi-byte sequence
   logic [u8d_pkg::LEN_W-1:0]  seq_len;
   logic [u8d_pkg::HELD_W-1:0] seq_held;
   logic [u8d_pkg::CP_W-1:0]   seq_bits;

   // results of the request being decoded, then the queue of all outstanding ones
   u8d_pkg::rsp_type step_points [4];
   int               step_count;
   u8d_pkg::rsp_type expected_points [$];
   int               mismatches;

   function automatic void add_point(input logic [u8d_pkg::CP_W-1:0] cp, input logic bad);
      u8d_pkg::rsp_type p;
      p = '0;
      p.code_point = cp;
      p.is_invalid = bad;
      step_points[step_count] = p;
      step_count++;
   endfunction

   function automatic void close_seq();
      seq_len  = u8d_pkg::LEN_NONE;
      seq_held = '0;
      seq_bits = '0;
   endfunction

   // one invalid per byte held by the broken sequence
   function automatic void drop_held();
      for (int i = 0; i < seq_held; i++)
         add_point('0, 1'b1);
      close_seq();
   endfunction

   // byte seen as a lead: ascii, opener, or bad lead
   function automatic void take_lead_byte(input logic [u8d_pkg::BYTE_W-1:0] b,
                                          input logic last);
      logic [u8d_pkg::LEN_W-1:0]  len;
      logic [u8d_pkg::BYTE_W-1:0] mask;
      len = u8d_pkg::LEN_NONE;
      if (!b[7]) begin
         add_point({13'd0, b}, 1'b0);
         return;
      end
      if (b[7:5] == u8d_pkg::TAG_LEAD2)
         len = u8d_pkg::LEN_TWO;
      else if (b[7:4] == u8d_pkg::TAG_LEAD3)
         len = u8d_pkg::LEN_THREE;
      else if (b[7:3] == u8d_pkg::TAG_LEAD4)
         len = u8d_pkg::LEN_FOUR;
      // bad lead, or an opener that cannot finish before end of text
      if (len == u8d_pkg::LEN_NONE || last) begin
         add_point('0, 1'b1);
         return;
      end
      mask     = 8'hFF >> (int'(len) + 1);
      seq_len  = len;
      seq_held = 2'd1;
      seq_bits = {13'd0, b & mask};
   endfunction

   function automatic void decode_byte(input u8d_pkg::req_type r);
      logic [u8d_pkg::BYTE_W-1:0] b;
      logic                       last;
      b = r.byte_value;
      last = r.end_of_text;
      step_count = 0;
      if (seq_len != u8d_pkg::LEN_NONE) begin
         if (b[7:6] == u8d_pkg::TAG_CONT) begin
            seq_bits = {seq_bits[u8d_pkg::CP_W-7:0], b[5:0]};
            seq_held = seq_held + 2'd1;
            // held count wraps to zero when a four-byte sequence completes
            if ({1'b0, seq_held} == seq_len || seq_held == '0) begin
               add_point(seq_bits, 1'b0);
               close_seq();
            end else if (last) begin
               drop_held();
            end
         end else begin
            drop_held();
            take_lead_byte(b, last);
         end
      end else begin
         take_lead_byte(b, last);
      end
      if (last)
         close_seq();
      if (step_count > 0) begin
         step_points[step_count-1].last_of_run = 1'b1;
         step_points[step_count-1].text_done   = last;
      end
      for (int i = 0; i < step_count; i++)
         expected_points.push_back(step_points[i]);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // compare results, then predict from the request taken at the same edge
   always @(posedge clock) begin
      u8d_pkg::rsp_type want;
      if (reset) begin
         close_seq();
         expected_points.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $display("%0t ns: unexpected result: expected none, actual cp %0h inv %0b",
                        $time, rsp_data.code_point, rsp_data.is_invalid);
               mismatches++;
            end else begin
               want = expected_points.pop_front();
               check_field("code_point", want.code_point, rsp_data.code_point);
               check_field("is_invalid", want.is_invalid, rsp_data.is_invalid);
               check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
               check_field("text_done", want.text_done, rsp_data.text_done);
            end
         end
         if (req_valid && req_ready)
            decode_byte(req_data);
      end
      mismatch_count <= mismatches;
      points_pending <= expected_points.size();
   end

endmodule

>>> test/tb.sv
// testbench top: byte stimulus, random stalls, watchdog and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 400;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   u8d_pkg::req_type req_data  = '0;
   logic             rsp_ready = 1'b0;
   logic             req_ready;
   logic             rsp_valid;
   u8d_pkg::rsp_type rsp_data;

   int mismatch_count;
   int points_pending;
   int idle_cycles = 0;
   int bytes_sent  = 0;
   bit no_gaps     = 1'b0;

   always #2 clock = ~clock;

   utf8_stream_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   u8d_code_point_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .points_pending (points_pending)
   );

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      if (no_gaps)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // one request; valid stays high across back-to-back bytes
   task automatic send_byte(input logic [u8d_pkg::BYTE_W-1:0] b, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.byte_value  <= b;
      req_data.end_of_text <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // a text of random characters, mostly well formed, some truncated, corrupted or noise
   task automatic send_text();
      int chars;
      int kind;
      int len;
      int n;
      logic [u8d_pkg::BYTE_W-1:0] rnd;
      logic [u8d_pkg::BYTE_W-1:0] seq [4];
      logic eot;
      chars = $urandom_range(1, 12);
      for (int c = 0; c < chars; c++) begin
         kind = $urandom_range(0, 99);
         len = $urandom_range(1, 4);
         rnd = 8'($urandom);
         case (len)
            1: seq[0] = {1'b0, rnd[6:0]};
            2: seq[0] = {u8d_pkg::TAG_LEAD2, rnd[4:0]};
            3: seq[0] = {u8d_pkg::TAG_LEAD3, rnd[3:0]};
            default: seq[0] = {u8d_pkg::TAG_LEAD4, rnd[2:0]};
         endcase
         for (int k = 1; k < 4; k++) begin
            rnd = 8'($urandom);
            seq[k] = {u8d_pkg::TAG_CONT, rnd[5:0]};
         end
         n = len;
         if (kind >= 95) begin
            seq[0] = 8'($urandom);
            n = 1;
         end else if (kind >= 90) begin
            seq[$urandom_range(0, len - 1)] = 8'($urandom);
         end else if (kind >= 80 && len > 1) begin
            n = $urandom_range(1, len - 1);
         end
         for (int k = 0; k < n; k++) begin
            eot = (c == chars - 1 && k == n - 1) || ($urandom_range(0, 49) == 0);
            send_byte(seq[k], eot);
         end
      end
   endtask

   // result side stalls
   initial begin
      int run_len;
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         run_len = no_gaps ? 30 : $urandom_range(1, 20);
         rsp_ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      int random_end;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ascii extremes
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      // two, three and four byte sequences
      send_byte(8'hC2, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'h80, 1'b0);
      // largest four byte value, completed on the final byte of the text
      send_byte(8'hF7, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
      // bad leads: lone continuation, all ones, five byte form
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hF8, 1'b0);
      // sequence broken by ascii after three held bytes
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'h41, 1'b0);
      // opener on the final byte
      send_byte(8'hE2, 1'b1);
      // sequence cut off by end of text
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);

      // random texts, some with no idling on either side
      random_end = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < random_end) begin
         no_gaps = ($urandom_range(0, 9) == 0);
         send_text();
      end
      req_valid <= 1'b0;
      no_gaps = 1'b0;

      // drain outstanding results
      @(posedge clock);
      while (points_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && points_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
